[hdl/cmmd_pkg.sv]
// package for the conveyor mode and motor drive block
// types, mode codes, symbol codes and the speed/duty arithmetic helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cmmd_pkg;

    localparam int RAW_W   = 10;
    localparam int SPEED_W = 8;
    localparam int DUTY_W  = 8;
    localparam int SYM_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [RAW_W-1:0] CENTRE_RESET    = 10'd512;
    localparam logic [RAW_W-1:0] DEAD_ZONE_RESET = 10'd50;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 2'd1;

    localparam logic [SYM_W-1:0] SYM_DASH    = 2'd0;
    localparam logic [SYM_W-1:0] SYM_ACTIVE  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_FORWARD = 2'd2;
    localparam logic [SYM_W-1:0] SYM_REVERSE = 2'd3;

    localparam logic signed [SPEED_W-1:0] SPEED_LO = -8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_HI = 8'sd100;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ARMED  = 2'd1,
        MODE_MANUAL = 2'd2,
        MODE_HOLD   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [RAW_W-1:0] joystick_raw;
        logic             click;
        logic             long_press;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]         duty_forward;
        logic [DUTY_W-1:0]         duty_reverse;
        logic signed [SPEED_W-1:0] speed_pct;
        logic [SYM_W-1:0]          symbol_id;
        logic                      running;
    } out_item_t;

    typedef struct packed {
        logic [RAW_W-1:0] centre;
        logic [RAW_W-1:0] dead_zone;
    } cfg_t;

    // raw*200/1023 - 100; quotient by 1023 is x>>10 plus at most one correction
    function automatic logic signed [SPEED_W-1:0] raw_to_pct(input logic [RAW_W-1:0] raw);
        logic [17:0] x;
        logic [7:0]  q0;
        logic [17:0] r;
        logic [7:0]  q;
        logic [8:0]  p;
        x  = ({8'd0, raw} << 7) + ({8'd0, raw} << 6) + ({8'd0, raw} << 3);
        q0 = x[17:10];
        r  = x - {q0, 10'd0} + {10'd0, q0};
        q  = (r >= 18'd1023) ? q0 + 8'd1 : q0;
        p  = {1'b0, q} - 9'd100;
        return p[SPEED_W-1:0];
    endfunction

    // mag*255/100 with mag in 0..100; /100 as multiply by 5243 and shift by 19
    function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [6:0] mag);
        logic [14:0] x;
        logic [27:0] prod;
        x    = ({8'd0, mag} << 8) - {8'd0, mag};
        prod = {13'd0, x} * 28'd5243;
        return prod[26:19];
    endfunction

    function automatic logic [SYM_W-1:0] symbol_of(input logic signed [SPEED_W-1:0] s);
        if (s > 0)
            return SYM_FORWARD;
        else if (s < 0)
            return SYM_REVERSE;
        return SYM_ACTIVE;
    endfunction

endpackage

`default_nettype wire

[hdl/cmmd_cfg.sv]
// configuration registers: joystick centre and dead zone
// depends on cmmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmmd_cfg
    import cmmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [RAW_W-1:0]     wr_data,
    output cfg_t                      cfg
);

    logic [RAW_W-1:0] centre_reg;
    logic [RAW_W-1:0] dead_zone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg    <= CENTRE_RESET;
            dead_zone_reg <= DEAD_ZONE_RESET;
        end
        else if (wr_en)
        begin
            // unknown indexes fall through and change nothing
            case (wr_index)
                CFG_CENTRE:    centre_reg    <= wr_data;
                CFG_DEAD_ZONE: dead_zone_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    assign cfg = {centre_reg, dead_zone_reg};

endmodule

`default_nettype wire

[hdl/cmmd_ctrl.sv]
// mode state machine, held speed and per-tick result logic
// depends on cmmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module cmmd_ctrl
    import cmmd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    mode_t                     mode_reg, mode_next;
    logic signed [SPEED_W-1:0] held_speed_reg, held_speed_next;

    logic [RAW_W:0]            diff;
    logic [RAW_W-1:0]          zone_dist;
    logic                      outside;
    logic signed [SPEED_W-1:0] manual_speed;
    logic signed [SPEED_W-1:0] speed;
    logic [SYM_W-1:0]          sym;
    logic [6:0]                mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            held_speed_reg <= '0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            held_speed_reg <= held_speed_next;
        end
    end

    // exact |raw - centre| with one extra bit for the borrow
    always_comb
    begin
        diff      = {1'b0, item.joystick_raw} - {1'b0, cfg.centre};
        zone_dist = diff[RAW_W] ? (cfg.centre - item.joystick_raw) : diff[RAW_W-1:0];
        outside   = zone_dist > cfg.dead_zone;
    end

    assign manual_speed = raw_to_pct(item.joystick_raw);

    always_comb
    begin
        mode_next       = mode_reg;
        held_speed_next = held_speed_reg;
        speed           = '0;
        sym             = SYM_DASH;
        case (mode_reg)
            MODE_IDLE:
            begin
                if (item.long_press)
                    mode_next = MODE_ARMED;
            end
            MODE_ARMED:
            begin
                sym = SYM_ACTIVE;
                if (item.long_press)
                    mode_next = MODE_IDLE;
                else if (outside)
                    mode_next = MODE_MANUAL;
            end
            MODE_MANUAL:
            begin
                speed = manual_speed;
                sym   = symbol_of(manual_speed);
                if (item.long_press)
                    mode_next = MODE_IDLE;
                else if (item.click)
                begin
                    held_speed_next = manual_speed;
                    mode_next       = MODE_HOLD;
                end
                else if (!outside)
                    mode_next = MODE_ARMED;
            end
            MODE_HOLD:
            begin
                speed = held_speed_reg;
                sym   = symbol_of(held_speed_reg);
                if (item.long_press)
                    mode_next = MODE_IDLE;
                else if (item.click)
                    mode_next = MODE_MANUAL;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    assign mag = speed[SPEED_W-1] ? 7'(-speed) : speed[6:0];

    always_comb
    begin
        result.duty_forward = '0;
        result.duty_reverse = '0;
        if (speed > 0)
            result.duty_forward = pct_to_duty(mag);
        else if (speed < 0)
            result.duty_reverse = pct_to_duty(mag);
        result.speed_pct = speed;
        result.symbol_id = sym;
        result.running   = (mode_next != MODE_IDLE);
    end

`ifndef NO_ASSERTIONS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_speed_reg >= SPEED_LO && held_speed_reg <= SPEED_HI)
        else $error("held speed out of range");

    a_idle_arms: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.long_press && mode_reg == MODE_IDLE |=> mode_reg == MODE_ARMED)
        else $error("long press in idle did not arm");

    a_hold_resume: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.click && !item.long_press && mode_reg == MODE_HOLD
        |=> mode_reg == MODE_MANUAL)
        else $error("click in hold did not resume manual");
`endif

endmodule

`default_nettype wire

[hdl/conveyor_mode_motor_drive.sv]
// top level of the conveyor mode and motor drive block
// depends on cmmd_pkg, cmmd_cfg, cmmd_ctrl
//
//  channel   signals                          direction  content
//  in        in_valid/in_ready/in_data         sink      joystick sample, click, long press
//  out       out_valid/out_ready/out_data      source    duties, speed, symbol, running
//  cfg       cfg_valid/cfg_ready/cfg_index/... sink      centre (0) and dead zone (1)
//
// one request per cycle sustained while the result side is ready; a request passes through two registers
// the input register feeds one pass of mode and speed logic into the result register
// mode and held speed update when a request moves from the input to the result register
// a stalled result holds the result register and a full input register; reset returns to idle, centre 512, dead zone 50
`timescale 1ns / 1ps
`default_nettype none

module conveyor_mode_motor_drive
    import cmmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [RAW_W-1:0]     cfg_data
);

    logic      a_valid_reg, a_valid_next;
    in_item_t  a_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    logic      advance_out;
    logic      move;
    logic      in_accept;
    cfg_t      cfg;
    out_item_t result;

    assign cfg_ready   = 1'b1;
    assign advance_out = !out_valid_reg || out_ready;
    assign move        = a_valid_reg && advance_out;
    assign in_ready    = !a_valid_reg || advance_out;
    assign in_accept   = in_valid && in_ready;

    cmmd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    cmmd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .item   (a_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        if (in_accept)
            a_valid_next = 1'b1;
        else if (advance_out)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            a_item_reg <= in_data;
        if (move)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_item_reg.duty_forward != '0 && out_item_reg.duty_reverse != '0))
        else $error("forward and reverse duty both driven");

    a_forward_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.symbol_id == SYM_FORWARD
        |-> out_item_reg.speed_pct > 0 && out_item_reg.duty_forward != '0)
        else $error("forward symbol without forward speed");

    a_dash_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.symbol_id == SYM_DASH
        |-> out_item_reg.speed_pct == 0 && out_item_reg.duty_reverse == '0)
        else $error("idle symbol with nonzero drive");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for conveyor_mode_motor_drive: directed and random joystick requests, checked per tick
// against a mode/speed predictor held here; depends on cmmd_pkg and the block's rtl only
`timescale 1ns / 1ps

module tb;
    import cmmd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int MAX_REPORTS = 100;

    // indexes past the register list, writes there must not change anything
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RAW_W-1:0]     cfg_data;

    conveyor_mode_motor_drive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [RAW_W-1:0] zone_centre;
    logic [RAW_W-1:0] zone_width;
    mode_t            motor_mode;
    int               held_pct;

    out_item_t drive_expected[$];

    int errors;
    int ticks_sent;
    int ticks_checked;
    int reg_writes;
    int cycles;
    int mode_ticks[4];

    bit tx_steady;
    bit rx_steady;
    bit hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit outside_dead_zone(input logic [RAW_W-1:0] raw);
        int d;
        d = int'(raw) - int'(zone_centre);
        if (d < 0)
            d = -d;
        return d > int'(zone_width);
    endfunction

    function automatic int pct_of_raw(input logic [RAW_W-1:0] raw);
        int p;
        p = int'(raw) * 200 / 1023 - 100;
        if (p < -100)
            p = -100;
        if (p > 100)
            p = 100;
        return p;
    endfunction

    function automatic logic [SYM_W-1:0] arrow_for(input int spd);
        if (spd > 0)
            return SYM_FORWARD;
        if (spd < 0)
            return SYM_REVERSE;
        return SYM_ACTIVE;
    endfunction

    // one tick: speed and symbol from the mode at entry, then the mode moves on
    function automatic out_item_t next_drive(input in_item_t it);
        out_item_t        r;
        int               spd;
        logic [SYM_W-1:0] sym;
        spd = 0;
        sym = SYM_DASH;
        mode_ticks[motor_mode]++;
        case (motor_mode)
            MODE_IDLE:
            begin
                if (it.long_press)
                    motor_mode = MODE_ARMED;
            end
            MODE_ARMED:
            begin
                sym = SYM_ACTIVE;
                if (it.long_press)
                    motor_mode = MODE_IDLE;
                else if (outside_dead_zone(it.joystick_raw))
                    motor_mode = MODE_MANUAL;
            end
            MODE_MANUAL:
            begin
                spd = pct_of_raw(it.joystick_raw);
                sym = arrow_for(spd);
                if (it.long_press)
                    motor_mode = MODE_IDLE;
                else if (it.click)
                begin
                    held_pct = spd;
                    motor_mode = MODE_HOLD;
                end
                else if (!outside_dead_zone(it.joystick_raw))
                    motor_mode = MODE_ARMED;
            end
            default:
            begin
                spd = held_pct;
                if (spd > 100)
                    spd = 100;
                if (spd < -100)
                    spd = -100;
                sym = arrow_for(spd);
                if (it.long_press)
                    motor_mode = MODE_IDLE;
                else if (it.click)
                    motor_mode = MODE_MANUAL;
            end
        endcase
        r.duty_forward = (spd > 0) ? 8'(spd * 255 / 100) : 8'd0;
        r.duty_reverse = (spd < 0) ? 8'(-spd * 255 / 100) : 8'd0;
        r.speed_pct    = 8'(spd);
        r.symbol_id    = sym;
        r.running      = (motor_mode != MODE_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // monitor: register writes, accepted requests and accepted results
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_CENTRE:    zone_centre = cfg_data;
                    CFG_DEAD_ZONE: zone_width  = cfg_data;
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                drive_expected.push_back(next_drive(in_data));
                ticks_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (drive_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t mismatch: result with nothing expected, actual %h",
                                 $time, out_data);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    ticks_checked++;
                    check_field("duty_forward", want.duty_forward, out_data.duty_forward);
                    check_field("duty_reverse", want.duty_reverse, out_data.duty_reverse);
                    check_field("speed_pct", want.speed_pct, out_data.speed_pct);
                    check_field("symbol_id", want.symbol_id, out_data.symbol_id);
                    check_field("running", want.running, out_data.running);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t timeout with %0d results outstanding", $time, drive_expected.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off counted here
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                hold_off_req = 1'b0;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(negedge clk);
            end
            else
                out_ready <= rx_steady || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic send_tick(input int raw, input bit click, input bit lp);
        in_item_t it;
        it.joystick_raw = raw[RAW_W-1:0];
        it.click        = click;
        it.long_press   = lp;
        @(negedge clk);
        while (!tx_steady && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_input();
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[RAW_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_zone(input int centre, input int width);
        wait_drained();
        write_reg(CFG_CENTRE, centre);
        write_reg(CFG_DEAD_ZONE, width);
    endtask

    // raw sample biased toward the dead zone edges and the rails
    function automatic int pick_raw();
        int w;
        int v;
        case ($urandom_range(0, 3))
            0, 1: v = $urandom_range(0, 1023);
            2:
            begin
                w = int'(zone_width) + 3;
                v = int'(zone_centre) + int'($urandom_range(0, 2 * w)) - w;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 1022;
                    default: v = 1023;
                endcase
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v;
    endfunction

    // reset values: centre 512, dead zone 50
    task automatic test_directed_modes();
        send_tick(512, 0, 0);     // idle
        send_tick(512, 1, 0);     // click in idle is ignored
        send_tick(1023, 0, 1);    // long press arms
        send_tick(1023, 1, 0);    // armed sees outside zone, click ignored -> manual
        send_tick(1023, 0, 0);    // full forward
        send_tick(0, 0, 0);       // full reverse
        send_tick(563, 0, 0);     // just outside above centre
        send_tick(562, 0, 0);     // distance equals dead zone -> armed
        send_tick(462, 0, 0);     // inside below, stays armed
        send_tick(461, 0, 0);     // just outside below -> manual
        send_tick(0, 1, 0);       // hold at -100
        send_tick(1023, 0, 0);    // hold ignores the sample
        send_tick(700, 0, 0);
        send_tick(300, 1, 1);     // long press beats click in hold
        send_tick(512, 0, 1);     // arm again
        send_tick(900, 0, 0);     // -> manual
        send_tick(900, 1, 1);     // long press beats click in manual
        send_tick(512, 0, 1);
        send_tick(1023, 0, 0);
        send_tick(1023, 1, 0);    // hold at +100
        send_tick(512, 1, 0);     // second click resumes manual
        send_tick(512, 0, 0);     // inside zone, speed near zero -> armed
        send_tick(512, 0, 1);     // long press in armed -> idle
        send_tick(512, 0, 0);
        wait_drained();
    endtask

    task automatic test_register_settings();
        wait_drained();
        write_reg(CFG_SPARE_A, 10'h3FF);
        write_reg(CFG_SPARE_B, 10'h000);
        send_tick(512, 0, 1);
        send_tick(562, 0, 0);     // still centred at 512 with zone 50
        send_tick(563, 0, 0);
        send_tick(512, 0, 1);

        set_zone(0, 0);
        send_tick(0, 0, 1);
        send_tick(0, 0, 0);       // zero distance is inside
        send_tick(1, 0, 0);       // -> manual
        send_tick(0, 0, 0);       // -> armed
        send_tick(0, 0, 1);

        set_zone(1023, 1023);     // nothing is ever outside
        send_tick(0, 0, 1);
        send_tick(0, 0, 0);
        send_tick(1023, 0, 0);
        send_tick(0, 0, 1);

        set_zone(1023, 0);
        send_tick(1023, 0, 1);
        send_tick(1022, 0, 0);
        send_tick(1022, 1, 0);
        send_tick(1023, 0, 1);

        set_zone(10'h2AA, 10'h155);
        for (int i = 0; i < 20; i++)
            send_tick(pick_raw(), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        set_zone(10'h155, 10'h2AA);
        for (int i = 0; i < 20; i++)
            send_tick(pick_raw(), $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
        set_zone(CENTRE_RESET, DEAD_ZONE_RESET);
    endtask

    // receiver stops while requests keep coming, so the block backs up
    task automatic test_input_stall();
        wait_drained();
        tx_steady = 1'b1;
        hold_off_req = 1'b1;
        send_tick(512, 0, 1);
        send_tick(1023, 0, 0);
        for (int i = 0; i < 40; i++)
            send_tick(pick_raw(), $urandom_range(0, 7) == 0, $urandom_range(0, 19) == 0);
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_ticks();
        int width;
        for (int seg = 0; seg < 10; seg++)
        begin
            if ($urandom_range(0, 3) == 0)
                width = $urandom_range(0, 1023);
            else
                width = $urandom_range(0, 200);
            set_zone($urandom_range(0, 1023), width);
            tx_steady = (seg == 5);
            rx_steady = (seg == 5);
            for (int i = 0; i < 110; i++)
                send_tick(pick_raw(), $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 6);
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CENTRE;
        cfg_data    = '0;
        zone_centre = CENTRE_RESET;
        zone_width  = DEAD_ZONE_RESET;
        motor_mode  = MODE_IDLE;
        held_pct    = 0;
        errors      = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_off_req = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_modes();
        test_register_settings();
        test_input_stall();
        test_random_ticks();

        $display("covered %0d requests, %0d results checked, %0d register writes",
                 ticks_sent, ticks_checked, reg_writes);
        $display("ticks entered in idle %0d, armed %0d, manual %0d, hold %0d",
                 mode_ticks[MODE_IDLE], mode_ticks[MODE_ARMED],
                 mode_ticks[MODE_MANUAL], mode_ticks[MODE_HOLD]);
        if (errors == 0 && drive_expected.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
